// File: hw/rtl/grc_pkg.sv
// Package for the gamepad report conditioner.
// Holds the controller-to-datapath command and status types and fixed constants.
// Used by grc_ctrl, grc_dp and gamepad_report_conditioner_top; depends on nothing.
package grc_pkg;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_SQDZ,
      OP_CHECK,
      OP_ROOT,
      OP_SCALE,
      OP_DIV,
      OP_SAVE,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      stick;
   } dp_cmd_type;

   typedef struct packed {
      logic poll_ok;
      logic reject;
   } dp_status_type;

   localparam logic        CSR_LEFT_DZ    = 1'b0;
   localparam logic        CSR_RIGHT_DZ   = 1'b1;
   localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
   localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
   localparam logic [14:0] AXIS_MAX       = 15'h7fff;
   localparam logic [31:0] ROOT_BIT_INIT  = 32'h4000_0000;
   localparam logic [3:0]  ITER_LAST      = 4'd15;
   localparam logic        STICK_LEFT     = 1'b0;
   localparam logic        STICK_RIGHT    = 1'b1;

endpackage

// File: hw/rtl/grc_dp.sv
// Datapath of the gamepad report conditioner: input word, history, dead-zone registers,
// shared squarer, bit-serial square root, bit-serial divider and the result word register.
// Depends on grc_pkg for the command and status types and constants.
module grc_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  grc_pkg::dp_cmd_type  cmd,
   output grc_pkg::dp_status_type status,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [14:0]          csr_write_data,
   input  logic                 req_poll_ok,
   input  logic [15:0]          req_button_word,
   input  logic [7:0]           req_trigger_left_raw,
   input  logic [7:0]           req_trigger_right_raw,
   input  logic signed [15:0]   req_left_x_raw,
   input  logic signed [15:0]   req_left_y_raw,
   input  logic signed [15:0]   req_right_x_raw,
   input  logic signed [15:0]   req_right_y_raw,
   output logic                 rsp_read_error,
   output logic [15:0]          rsp_buttons_now,
   output logic [15:0]          rsp_buttons_changed,
   output logic [15:0]          rsp_trigger_left_level,
   output logic [15:0]          rsp_trigger_right_level,
   output logic [3:0]           rsp_analog_changed,
   output logic [15:0]          rsp_left_magnitude,
   output logic [15:0]          rsp_right_magnitude,
   output logic signed [15:0]   rsp_left_x_out,
   output logic signed [15:0]   rsp_left_y_out,
   output logic signed [15:0]   rsp_right_x_out,
   output logic signed [15:0]   rsp_right_y_out
);

   logic        ok_ff;
   logic [15:0] btn_ff;
   logic [7:0]  tl_ff, tr_ff;
   logic [15:0] lx_ff, ly_ff, rx_ff, ry_ff;
   logic [15:0] prev_btn_ff;
   logic [15:0] prev_trig_ff;
   logic [63:0] prev_axes_ff;
   logic [14:0] left_dz_ff, right_dz_ff;
   logic [31:0] sum_ff;
   logic [29:0] dz2_ff;
   logic        zero_ff;
   logic [31:0] rem_ff, root_ff, bit_ff;
   logic [14:0] drem_ff;
   logic [15:0] quo_ff;
   logic [15:0] left_mag_ff, right_mag_ff;

   logic [15:0] sel_x, sel_y;
   logic [16:0] abs_x, abs_y;
   logic [14:0] dz;
   logic [16:0] mul_a;
   logic [33:0] prod;
   logic [31:0] trial;
   logic        root_ge;
   logic [14:0] cap, diff, divisor;
   logic [30:0] num;
   logic [15:0] div_t;
   logic        div_ge;
   logic [15:0] div_sub;
   logic [3:0]  chg;
   logic [15:0] tl_level, tr_level;

   always_comb begin
      sel_x = (cmd.stick == grc_pkg::STICK_RIGHT) ? rx_ff : lx_ff;
      sel_y = (cmd.stick == grc_pkg::STICK_RIGHT) ? ry_ff : ly_ff;
      dz    = (cmd.stick == grc_pkg::STICK_RIGHT) ? right_dz_ff : left_dz_ff;
      abs_x = sel_x[15] ? (17'h10000 - {1'b0, sel_x}) : {1'b0, sel_x};
      abs_y = sel_y[15] ? (17'h10000 - {1'b0, sel_y}) : {1'b0, sel_y};
      case (cmd.op)
         grc_pkg::OP_SQX: mul_a = abs_x;
         grc_pkg::OP_SQY: mul_a = abs_y;
         default:         mul_a = {2'b00, dz};
      endcase
      prod    = {17'd0, mul_a} * {17'd0, mul_a};
      trial   = root_ff + bit_ff;
      root_ge = rem_ff >= trial;
      cap     = (root_ff > {17'd0, grc_pkg::AXIS_MAX}) ? grc_pkg::AXIS_MAX : root_ff[14:0];
      diff    = cap - dz;
      num     = {diff, 16'd0} - {16'd0, diff};
      divisor = grc_pkg::AXIS_MAX - dz;
      div_t   = {drem_ff, quo_ff[15]};
      div_ge  = div_t >= {1'b0, divisor};
      div_sub = div_t - {1'b0, divisor};
      chg[0]  = tl_ff != prev_trig_ff[7:0];
      chg[1]  = tr_ff != prev_trig_ff[15:8];
      chg[2]  = (lx_ff != prev_axes_ff[15:0]) || (ly_ff != prev_axes_ff[31:16]);
      chg[3]  = (rx_ff != prev_axes_ff[47:32]) || (ry_ff != prev_axes_ff[63:48]);
      tl_level = {tl_ff, tl_ff};
      tr_level = {tr_ff, tr_ff};
      status.poll_ok = ok_ff;
      status.reject  = (sum_ff <= {2'b00, dz2_ff}) || (dz == grc_pkg::AXIS_MAX);
   end

   // Configuration and report history.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_dz_ff   <= grc_pkg::LEFT_DZ_RESET;
         right_dz_ff  <= grc_pkg::RIGHT_DZ_RESET;
         prev_btn_ff  <= 16'd0;
         prev_trig_ff <= 16'd0;
         prev_axes_ff <= 64'd0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               grc_pkg::CSR_LEFT_DZ:  left_dz_ff  <= csr_write_data;
               grc_pkg::CSR_RIGHT_DZ: right_dz_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.op == grc_pkg::OP_FINISH && ok_ff) begin
            prev_btn_ff  <= btn_ff;
            prev_trig_ff <= {tr_ff, tl_ff};
            prev_axes_ff <= {ry_ff, rx_ff, ly_ff, lx_ff};
         end
      end
   end

   // Working registers and result word.
   always_ff @(posedge clock) begin
      case (cmd.op)
         grc_pkg::OP_LOAD: begin
            ok_ff  <= req_poll_ok;
            btn_ff <= req_button_word;
            tl_ff  <= req_trigger_left_raw;
            tr_ff  <= req_trigger_right_raw;
            lx_ff  <= req_left_x_raw;
            ly_ff  <= req_left_y_raw;
            rx_ff  <= req_right_x_raw;
            ry_ff  <= req_right_y_raw;
         end
         grc_pkg::OP_SQX: sum_ff <= prod[31:0];
         grc_pkg::OP_SQY: sum_ff <= sum_ff + prod[31:0];
         grc_pkg::OP_SQDZ: dz2_ff <= prod[29:0];
         grc_pkg::OP_CHECK: begin
            zero_ff <= status.reject;
            rem_ff  <= sum_ff;
            root_ff <= 32'd0;
            bit_ff  <= grc_pkg::ROOT_BIT_INIT;
         end
         grc_pkg::OP_ROOT: begin
            if (root_ge) begin
               rem_ff  <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         grc_pkg::OP_SCALE: begin
            drem_ff <= num[30:16];
            quo_ff  <= num[15:0];
         end
         grc_pkg::OP_DIV: begin
            drem_ff <= div_ge ? div_sub[14:0] : div_t[14:0];
            quo_ff  <= {quo_ff[14:0], div_ge};
         end
         grc_pkg::OP_SAVE: begin
            if (cmd.stick == grc_pkg::STICK_RIGHT) begin
               right_mag_ff <= zero_ff ? 16'd0 : quo_ff;
            end else begin
               left_mag_ff <= zero_ff ? 16'd0 : quo_ff;
            end
         end
         grc_pkg::OP_FINISH: begin
            rsp_read_error <= ~ok_ff;
            if (ok_ff) begin
               rsp_buttons_now         <= btn_ff;
               rsp_buttons_changed     <= btn_ff ^ prev_btn_ff;
               rsp_trigger_left_level  <= tl_level;
               rsp_trigger_right_level <= tr_level;
               rsp_analog_changed      <= chg;
               rsp_left_magnitude      <= left_mag_ff;
               rsp_right_magnitude     <= right_mag_ff;
               rsp_left_x_out          <= lx_ff;
               rsp_left_y_out          <= ly_ff;
               rsp_right_x_out         <= rx_ff;
               rsp_right_y_out         <= ry_ff;
            end else begin
               rsp_buttons_now         <= 16'd0;
               rsp_buttons_changed     <= 16'd0;
               rsp_trigger_left_level  <= 16'd0;
               rsp_trigger_right_level <= 16'd0;
               rsp_analog_changed      <= 4'd0;
               rsp_left_magnitude      <= 16'd0;
               rsp_right_magnitude     <= 16'd0;
               rsp_left_x_out          <= 16'sd0;
               rsp_left_y_out          <= 16'sd0;
               rsp_right_x_out         <= 16'sd0;
               rsp_right_y_out         <= 16'sd0;
            end
         end
         default: ;
      endcase
   end

endmodule

// File: hw/rtl/grc_ctrl.sv
// Controller of the gamepad report conditioner: sequences the datapath through both sticks
// for a good poll. Owns the request stall and the result valid flag; depends on grc_pkg.
module grc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  grc_pkg::dp_status_type status,
   output grc_pkg::dp_cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQX,
      S_SQY,
      S_SQDZ,
      S_CHECK,
      S_ROOT,
      S_SCALE,
      S_DIV,
      S_SAVE,
      S_FINISH
   } state_type;

   state_type   state_ff;
   logic        stick_ff;
   logic [3:0]  count_ff;
   logic        rsp_valid_ff;
   logic        can_finish;

   always_comb begin
      can_finish = ~rsp_valid_ff | ~rsp_stall;
      req_stall  = state_ff != S_IDLE;
      rsp_valid  = rsp_valid_ff;
      cmd.stick  = stick_ff;
      case (state_ff)
         S_IDLE:   cmd.op = req_valid ? grc_pkg::OP_LOAD : grc_pkg::OP_NONE;
         S_SQX:    cmd.op = grc_pkg::OP_SQX;
         S_SQY:    cmd.op = grc_pkg::OP_SQY;
         S_SQDZ:   cmd.op = grc_pkg::OP_SQDZ;
         S_CHECK:  cmd.op = grc_pkg::OP_CHECK;
         S_ROOT:   cmd.op = grc_pkg::OP_ROOT;
         S_SCALE:  cmd.op = grc_pkg::OP_SCALE;
         S_DIV:    cmd.op = grc_pkg::OP_DIV;
         S_SAVE:   cmd.op = grc_pkg::OP_SAVE;
         S_FINISH: cmd.op = can_finish ? grc_pkg::OP_FINISH : grc_pkg::OP_NONE;
         default:  cmd.op = grc_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stick_ff     <= grc_pkg::STICK_LEFT;
         count_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_FINISH && can_finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               stick_ff <= grc_pkg::STICK_LEFT;
               if (req_valid) begin
                  state_ff <= S_SQX;
               end
            end
            S_SQX: begin
               state_ff <= status.poll_ok ? S_SQY : S_FINISH;
            end
            S_SQY:  state_ff <= S_SQDZ;
            S_SQDZ: state_ff <= S_CHECK;
            S_CHECK: begin
               count_ff <= 4'd0;
               state_ff <= status.reject ? S_SAVE : S_ROOT;
            end
            S_ROOT: begin
               count_ff <= count_ff + 4'd1;
               if (count_ff == grc_pkg::ITER_LAST) begin
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               count_ff <= 4'd0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               count_ff <= count_ff + 4'd1;
               if (count_ff == grc_pkg::ITER_LAST) begin
                  state_ff <= S_SAVE;
               end
            end
            S_SAVE: begin
               if (stick_ff == grc_pkg::STICK_LEFT) begin
                  stick_ff <= grc_pkg::STICK_RIGHT;
                  state_ff <= S_SQX;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (can_finish) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: hw/rtl/gamepad_report_conditioner_top.sv
// A failed poll passes through S_SQX to S_FINISH, which registers its word; a valid poll also
// runs the 16-step square root and 16-step divider for each stick outside the dead zone.
// No new poll is taken until the last finishes; the shared root and divide unit is the limit.
// A finished word waits in the output register while the next one is accepted.
// Reset is synchronous: history clears to zero and the dead-zone registers take their defaults.
module gamepad_report_conditioner_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [14:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_poll_ok,
   input  logic [15:0]        req_button_word,
   input  logic [7:0]         req_trigger_left_raw,
   input  logic [7:0]         req_trigger_right_raw,
   input  logic signed [15:0] req_left_x_raw,
   input  logic signed [15:0] req_left_y_raw,
   input  logic signed [15:0] req_right_x_raw,
   input  logic signed [15:0] req_right_y_raw,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_read_error,
   output logic [15:0]        rsp_buttons_now,
   output logic [15:0]        rsp_buttons_changed,
   output logic [15:0]        rsp_trigger_left_level,
   output logic [15:0]        rsp_trigger_right_level,
   output logic [3:0]         rsp_analog_changed,
   output logic [15:0]        rsp_left_magnitude,
   output logic [15:0]        rsp_right_magnitude,
   output logic signed [15:0] rsp_left_x_out,
   output logic signed [15:0] rsp_left_y_out,
   output logic signed [15:0] rsp_right_x_out,
   output logic signed [15:0] rsp_right_y_out
);

   grc_pkg::dp_cmd_type    cmd;
   grc_pkg::dp_status_type status;

   grc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   grc_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data),
      .req_poll_ok             (req_poll_ok),
      .req_button_word         (req_button_word),
      .req_trigger_left_raw    (req_trigger_left_raw),
      .req_trigger_right_raw   (req_trigger_right_raw),
      .req_left_x_raw          (req_left_x_raw),
      .req_left_y_raw          (req_left_y_raw),
      .req_right_x_raw         (req_right_x_raw),
      .req_right_y_raw         (req_right_y_raw),
      .rsp_read_error          (rsp_read_error),
      .rsp_buttons_now         (rsp_buttons_now),
      .rsp_buttons_changed     (rsp_buttons_changed),
      .rsp_trigger_left_level  (rsp_trigger_left_level),
      .rsp_trigger_right_level (rsp_trigger_right_level),
      .rsp_analog_changed      (rsp_analog_changed),
      .rsp_left_magnitude      (rsp_left_magnitude),
      .rsp_right_magnitude     (rsp_right_magnitude),
      .rsp_left_x_out          (rsp_left_x_out),
      .rsp_left_y_out          (rsp_left_y_out),
      .rsp_right_x_out         (rsp_right_x_out),
      .rsp_right_y_out         (rsp_right_y_out)
   );

endmodule
